>>> hw/rtl/lvcd_pkg.sv
// Shared types, command tables and codes of the voice line command decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lvcd_pkg;

	localparam int LINE_CAPACITY_DEF = 32;
	localparam int CMD_COUNT         = 9;
	localparam int CMD_MAX           = 8;
	localparam int LANE_COUNT        = 4;

	localparam logic [7:0] PENDING_LIMIT_RESET = 8'd250;

	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_UPPER_S = 8'h53;
	localparam logic [7:0] CHAR_LOWER_S = 8'h73;

	typedef enum logic [2:0] {
		FUNC_BYTE          = 3'd0,
		FUNC_TAKE_STEP     = 3'd1,
		FUNC_TAKE_REC_START = 3'd2,
		FUNC_TAKE_REC_END  = 3'd3,
		FUNC_TAKE_PLAY     = 3'd4,
		FUNC_CLEAR_EXTEND  = 3'd5
	} func_t;

	typedef enum logic [3:0] {
		CMD_UNCON   = 4'd0,
		CMD_CON     = 4'd1,
		CMD_GRIP    = 4'd2,
		CMD_RELEASE = 4'd3,
		CMD_FOR     = 4'd4,
		CMD_COM     = 4'd5,
		CMD_REC     = 4'd6,
		CMD_END     = 4'd7,
		CMD_PLAY    = 4'd8,
		CMD_NONE    = 4'd9
	} cmd_t;

	localparam logic [7:0] CMD_TEXT [CMD_COUNT][CMD_MAX] = '{
		'{8'h55, 8'h6E, 8'h43, 8'h6F, 8'h6E, 8'h0A, 8'h00, 8'h00},
		'{8'h43, 8'h6F, 8'h6E, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h47, 8'h52, 8'h49, 8'h50, 8'h0A, 8'h00, 8'h00, 8'h00},
		'{8'h52, 8'h45, 8'h4C, 8'h45, 8'h41, 8'h53, 8'h45, 8'h0A},
		'{8'h66, 8'h6F, 8'h72, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h43, 8'h6F, 8'h6D, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h52, 8'h65, 8'h63, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h45, 8'h6E, 8'h64, 8'h0A, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h6C, 8'h61, 8'h79, 8'h0A, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] CMD_LEN [CMD_COUNT] = '{
		4'd6, 4'd4, 4'd5, 4'd8, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5
	};

	typedef struct packed {
		logic estop;
		cmd_t hit;
	} line_evt_t;

	typedef struct packed {
		logic emergency_stop;
		logic grip_pulse;
		logic release_pulse;
		logic granted;
		logic wireless_lock;
		logic extend_mode;
		logic recording;
		logic playing;
	} result_t;

endpackage
`default_nettype wire

>>> hw/rtl/lvcd_if.sv
// Input and result channels of the voice line command decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface lvcd_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [7:0] data_byte;

	modport source (output valid, output func, output data_byte, input ready);
	modport sink (input valid, input func, input data_byte, output ready);
endinterface

interface lvcd_out_if;
	logic valid;
	logic ready;
	logic emergency_stop;
	logic grip_pulse;
	logic release_pulse;
	logic granted;
	logic wireless_lock;
	logic extend_mode;
	logic recording;
	logic playing;

	modport source (output valid, output emergency_stop, output grip_pulse,
		output release_pulse, output granted, output wireless_lock,
		output extend_mode, output recording, output playing, input ready);
	modport sink (input valid, input emergency_stop, input grip_pulse,
		input release_pulse, input granted, input wireless_lock,
		input extend_mode, input recording, input playing, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/voice_line_command_decoder.sv
// Top level of the voice line command decoder: input register, decode, result register.
// Depends on lvcd_pkg, lvcd_if, lvcd_line_match, lvcd_cmd_exec.
// The decoder takes one item per clock cycle unless the result side stalls it, and returns
// exactly one result item for each from the output register. An item is held in
// the input register, decoded in a single pass of line match and flag/counter update,
// and the result lands in the output register; both registers advance together under
// result-side backpressure. The pending limit register may be written while idle.
`timescale 1ns / 1ps
`default_nettype none
module voice_line_command_decoder #(
	parameter int LINE_CAPACITY = lvcd_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	lvcd_in_if.sink         in_ch,
	lvcd_out_if.source      out_ch,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);
	logic              valid_s1, valid_s2;
	logic [2:0]        func_s1;
	logic [7:0]        byte_s1;
	logic [7:0]        limit_q;
	logic              adv_s2, adv_s1, is_byte;
	lvcd_pkg::line_evt_t evt;
	lvcd_pkg::result_t   res, res_s2;

	assign adv_s2      = !valid_s2 || out_ch.ready;
	assign adv_s1      = valid_s1 && adv_s2;
	assign in_ch.ready = !valid_s1 || adv_s2;
	assign is_byte     = (lvcd_pkg::func_t'(func_s1) == lvcd_pkg::FUNC_BYTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lvcd_pkg::PENDING_LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1 <= in_ch.func;
			byte_s1 <= in_ch.data_byte;
		end
	end

	lvcd_line_match #(
		.LINE_CAPACITY(LINE_CAPACITY)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (adv_s1),
		.is_byte   (is_byte),
		.data_byte (byte_s1),
		.evt       (evt)
	);

	lvcd_cmd_exec u_exec (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (adv_s1),
		.func          (func_s1),
		.evt           (evt),
		.pending_limit (limit_q),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_ch.valid          = valid_s2;
	assign out_ch.emergency_stop = res_s2.emergency_stop;
	assign out_ch.grip_pulse     = res_s2.grip_pulse;
	assign out_ch.release_pulse  = res_s2.release_pulse;
	assign out_ch.granted        = res_s2.granted;
	assign out_ch.wireless_lock  = res_s2.wireless_lock;
	assign out_ch.extend_mode    = res_s2.extend_mode;
	assign out_ch.recording      = res_s2.recording;
	assign out_ch.playing        = res_s2.playing;
endmodule
`default_nettype wire

>>> hw/rtl/lvcd_line_match.sv
// Line assembly and incremental command match; keeps previous byte, length, candidates.
// Depends on lvcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lvcd_line_match #(
	parameter int LINE_CAPACITY = lvcd_pkg::LINE_CAPACITY_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  wire logic              is_byte,
	input  wire logic [7:0]        data_byte,
	output lvcd_pkg::line_evt_t    evt
);
	localparam int LEN_W = $clog2(LINE_CAPACITY);
	localparam int CW    = LEN_W + 1;
	localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

	logic [7:0]                       prev_byte_q;
	logic [LEN_W-1:0]                 line_len_q;
	logic [lvcd_pkg::CMD_COUNT-1:0]   cand_q;
	logic [lvcd_pkg::CMD_COUNT-1:0]   cand_d;
	logic [LEN_W-1:0]                 line_len_d;
	logic [lvcd_pkg::CMD_COUNT-1:0]   len_fit;
	logic [lvcd_pkg::CMD_COUNT-1:0]   char_ok;
	logic                             is_nl;
	logic                             is_cr;
	logic                             full;

	assign is_nl = (data_byte == lvcd_pkg::CHAR_NL);
	assign is_cr = (data_byte == lvcd_pkg::CHAR_CR);
	assign full  = (line_len_q == LEN_LAST);

	always_comb begin
		for (int k = 0; k < lvcd_pkg::CMD_COUNT; k++) begin
			len_fit[k] = (CW'(lvcd_pkg::CMD_LEN[k]) == CW'(line_len_q) + CW'(1));
			char_ok[k] = (CW'(line_len_q) < CW'(lvcd_pkg::CMD_LEN[k])) &&
				(lvcd_pkg::CMD_TEXT[k][line_len_q[2:0]] == data_byte);
		end
	end

	always_comb begin
		evt.estop = is_byte && is_nl && ((prev_byte_q == lvcd_pkg::CHAR_UPPER_S) ||
			(prev_byte_q == lvcd_pkg::CHAR_LOWER_S));
		evt.hit = lvcd_pkg::CMD_NONE;
		if (is_byte && is_nl && !full) begin
			for (int k = lvcd_pkg::CMD_COUNT - 1; k >= 0; k--) begin
				if (cand_q[k] && len_fit[k]) begin
					evt.hit = lvcd_pkg::cmd_t'(k);
				end
			end
		end
	end

	always_comb begin
		cand_d     = cand_q;
		line_len_d = line_len_q;
		if (is_nl) begin
			cand_d     = '1;
			line_len_d = '0;
		end else if (!is_cr) begin
			if (full) begin
				cand_d = '0;
			end else begin
				cand_d     = cand_q & char_ok;
				line_len_d = line_len_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q <= '0;
			line_len_q  <= '0;
			cand_q      <= '1;
		end else if (advance && is_byte) begin
			prev_byte_q <= data_byte;
			line_len_q  <= line_len_d;
			cand_q      <= cand_d;
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/lvcd_cmd_exec.sv
// Command execution: lock and mode flags, four saturating pending counters.
// Depends on lvcd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lvcd_cmd_exec (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire logic [2:0]          func,
	input  wire lvcd_pkg::line_evt_t evt,
	input  wire logic [7:0]          pending_limit,
	output lvcd_pkg::result_t        res
);
	logic       lock_q, extend_q, record_q, play_q;
	logic       lock_d, extend_d, record_d, play_d;
	logic [7:0] pend_q [lvcd_pkg::LANE_COUNT];
	logic [7:0] pend_d [lvcd_pkg::LANE_COUNT];
	logic [lvcd_pkg::LANE_COUNT-1:0] take;
	logic [lvcd_pkg::LANE_COUNT-1:0] bump;
	logic [lvcd_pkg::LANE_COUNT-1:0] dec;
	logic       grip, rel, clr_step;
	lvcd_pkg::cmd_t act;

	// drop every line command but the lock changes while locked
	assign act = (lock_q && evt.hit != lvcd_pkg::CMD_UNCON && evt.hit != lvcd_pkg::CMD_CON)
		? lvcd_pkg::CMD_NONE : evt.hit;

	always_comb begin
		lock_d   = lock_q;
		extend_d = extend_q;
		record_d = record_q;
		play_d   = play_q;
		grip     = 1'b0;
		rel      = 1'b0;
		clr_step = 1'b0;
		bump     = '0;
		unique case (act)
			lvcd_pkg::CMD_UNCON:   lock_d = 1'b1;
			lvcd_pkg::CMD_CON:     lock_d = 1'b0;
			lvcd_pkg::CMD_GRIP:    grip = 1'b1;
			lvcd_pkg::CMD_RELEASE: rel = 1'b1;
			lvcd_pkg::CMD_FOR: begin
				extend_d = 1'b1;
				bump[0]  = 1'b1;
			end
			lvcd_pkg::CMD_COM: begin
				extend_d = 1'b0;
				clr_step = 1'b1;
			end
			lvcd_pkg::CMD_REC: begin
				play_d   = 1'b0;
				record_d = 1'b1;
				bump[1]  = 1'b1;
			end
			lvcd_pkg::CMD_END: begin
				record_d = 1'b0;
				bump[2]  = 1'b1;
			end
			lvcd_pkg::CMD_PLAY: begin
				record_d = 1'b0;
				play_d   = 1'b1;
				bump[3]  = 1'b1;
			end
			default: ;
		endcase
		take = '0;
		unique case (lvcd_pkg::func_t'(func))
			lvcd_pkg::FUNC_TAKE_STEP:      take[0] = 1'b1;
			lvcd_pkg::FUNC_TAKE_REC_START: take[1] = 1'b1;
			lvcd_pkg::FUNC_TAKE_REC_END:   take[2] = 1'b1;
			lvcd_pkg::FUNC_TAKE_PLAY:      take[3] = 1'b1;
			lvcd_pkg::FUNC_CLEAR_EXTEND: begin
				extend_d = 1'b0;
				clr_step = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		for (int i = 0; i < lvcd_pkg::LANE_COUNT; i++) begin
			dec[i]    = take[i] && (pend_q[i] != 8'd0);
			pend_d[i] = pend_q[i];
			if (dec[i]) begin
				pend_d[i] = pend_q[i] - 8'd1;
			end else if (bump[i] && (pend_q[i] < pending_limit)) begin
				pend_d[i] = pend_q[i] + 8'd1;
			end
		end
		if (clr_step) begin
			pend_d[0] = 8'd0;
		end
	end

	always_comb begin
		res.emergency_stop = evt.estop;
		res.grip_pulse     = grip;
		res.release_pulse  = rel;
		res.granted        = |dec;
		res.wireless_lock  = lock_d;
		res.extend_mode    = extend_d;
		res.recording      = record_d;
		res.playing        = play_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q   <= 1'b0;
			extend_q <= 1'b0;
			record_q <= 1'b0;
			play_q   <= 1'b0;
			for (int i = 0; i < lvcd_pkg::LANE_COUNT; i++) begin
				pend_q[i] <= 8'd0;
			end
		end else if (advance) begin
			lock_q   <= lock_d;
			extend_q <= extend_d;
			record_q <= record_d;
			play_q   <= play_d;
			for (int i = 0; i < lvcd_pkg::LANE_COUNT; i++) begin
				pend_q[i] <= pend_d[i];
			end
		end
	end
endmodule
`default_nettype wire
